>>> src/curve25519_field_alu_assert.svh
// Assertion macros used by the field unit RTL.
// Depends on nothing; included by curve25519_field_alu, which checks its own logic.
`ifndef CURVE25519_FIELD_ALU_ASSERT_SVH
`define CURVE25519_FIELD_ALU_ASSERT_SVH

// Checks a property on every rising clock edge outside of reset.
`define CFA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define CFA_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/cfa_pkg.sv
// Shared types and constants of the GF(2^255-19) arithmetic unit.
// Depends on nothing; used by cfa_mul, curve25519_field_alu and the testbench.
`timescale 1ns / 1ps

package cfa_pkg;

	typedef enum logic [2:0] {
		FUNC_ADD  = 3'd0,
		FUNC_SUB  = 3'd1,
		FUNC_MUL  = 3'd2,
		FUNC_SQR  = 3'd3,
		FUNC_RED  = 3'd4,
		FUNC_SWAP = 3'd5
	} func_t;

	localparam int unsigned ELEM_W = 256;
	localparam int unsigned LIMBS  = 8;
	localparam int unsigned LIMB_W = 32;
	localparam int unsigned PROD_W = 64;
	localparam int unsigned COLS   = 16;
	localparam int unsigned COL_W  = 67;
	localparam int unsigned FOLD_W = 73;
	localparam int unsigned LIN_W  = 259;
	localparam int unsigned WIDE_W = 301;
	localparam int unsigned FOLD_MUL = 38;
	localparam int unsigned TOP_MUL  = 19;

	localparam logic [ELEM_W-1:0] PRIME = (256'd1 << 255) - 256'd19;
	localparam logic [LIN_W-1:0] FOUR_P = LIN_W'(PRIME) << 2;

endpackage

>>> src/cfa_mul.sv
// Pipelined 256 by 256 bit multiplier with the first fold by 38.
// Depends on cfa_pkg; three register stages: the 32 by 32 bit products, the column sums and the fold.
`timescale 1ns / 1ps

module cfa_mul (
	input  logic clk,
	input  logic [cfa_pkg::ELEM_W-1:0] x,
	input  logic [cfa_pkg::ELEM_W-1:0] y,
	output logic [cfa_pkg::FOLD_W-1:0] fold_s4 [cfa_pkg::LIMBS]
);

	logic [cfa_pkg::PROD_W-1:0] pp_s2 [cfa_pkg::LIMBS][cfa_pkg::LIMBS];
	logic [cfa_pkg::COL_W-1:0] col_c [cfa_pkg::COLS];
	logic [cfa_pkg::COL_W-1:0] col_s3 [cfa_pkg::COLS];

	always_ff @(posedge clk) begin
		for (int i = 0; i < cfa_pkg::LIMBS; i++) begin
			for (int j = 0; j < cfa_pkg::LIMBS; j++) begin
				pp_s2[i][j] <= cfa_pkg::PROD_W'(x[cfa_pkg::LIMB_W*i +: cfa_pkg::LIMB_W]) *
					cfa_pkg::PROD_W'(y[cfa_pkg::LIMB_W*j +: cfa_pkg::LIMB_W]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < cfa_pkg::COLS; k++) begin
			col_c[k] = '0;
			for (int i = 0; i < cfa_pkg::LIMBS; i++) begin
				if (k - i >= 0 && k - i < cfa_pkg::LIMBS) begin
					col_c[k] = col_c[k] + cfa_pkg::COL_W'(pp_s2[i][k-i]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		col_s3 <= col_c;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < cfa_pkg::LIMBS; k++) begin
			fold_s4[k] <= cfa_pkg::FOLD_W'(col_s3[k]) +
				cfa_pkg::FOLD_W'(col_s3[k+cfa_pkg::LIMBS]) * cfa_pkg::FOLD_W'(cfa_pkg::FOLD_MUL);
		end
	end

endmodule

>>> src/curve25519_field_alu.sv
// Top level of the GF(2^255-19) arithmetic unit: input stage, reduction and output beats.
// Depends on cfa_pkg, cfa_mul and curve25519_field_alu_assert.svh.
`timescale 1ns / 1ps
`include "curve25519_field_alu_assert.svh"

// An item is taken when start is high and busy is low, one item every cycle while busy
// stays low. Its first result beat appears with done high once the item has passed eight
// register stages: the input register, the products, the column sums, the fold by 38,
// the wide sum, two reduction steps and the output register. Every opcode from add to
// reduce gives one beat, the canonical residue below p, with last high. Swap gives two
// beats, the second right after the first, and raises busy for a single cycle once taken.
// Opcodes six and seven give no beat. Beats cannot be held off, so the receiver must take
// each one when done is high.
module curve25519_field_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [63:0] a_word0,
	input  logic [63:0] a_word1,
	input  logic [63:0] a_word2,
	input  logic [63:0] a_word3,
	input  logic [63:0] b_word0,
	input  logic [63:0] b_word1,
	input  logic [63:0] b_word2,
	input  logic [63:0] b_word3,
	input  logic        swap_bit,
	output logic        done,
	output logic [63:0] out_word0,
	output logic [63:0] out_word1,
	output logic [63:0] out_word2,
	output logic [62:0] out_word3,
	output logic        last
);

	typedef struct packed {
		logic [2:0] func;
		logic swap;
		logic [cfa_pkg::ELEM_W-1:0] a;
		logic [cfa_pkg::ELEM_W-1:0] b;
		logic [cfa_pkg::LIN_W-1:0] lin;
	} side_t;

	logic busy_q;
	logic accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [cfa_pkg::ELEM_W-1:0] mul_b;
	logic [cfa_pkg::LIN_W-1:0] lin_c;
	logic [cfa_pkg::FOLD_W-1:0] fold_s4 [cfa_pkg::LIMBS];
	logic [cfa_pkg::WIDE_W-1:0] va, vb, vc;
	logic [cfa_pkg::WIDE_W-1:0] wide_s5;
	logic [cfa_pkg::ELEM_W-1:0] r1_s6, r2_s7;
	logic [cfa_pkg::ELEM_W:0] diff;
	logic [cfa_pkg::ELEM_W-1:0] res;
	logic emit_new;
	logic is_swap7;
	logic pend_q;
	logic [cfa_pkg::ELEM_W-1:0] pend_data_q, out_q;

	assign accept = start && !busy_q;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			busy_q <= accept && func == cfa_pkg::FUNC_SWAP;
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.func <= func;
		side_s1.swap <= swap_bit;
		side_s1.a <= {a_word3, a_word2, a_word1, a_word0};
		side_s1.b <= {b_word3, b_word2, b_word1, b_word0};
		side_s1.lin <= '0;
		side_s2.func <= side_s1.func;
		side_s2.swap <= side_s1.swap;
		side_s2.a <= side_s1.a;
		side_s2.b <= side_s1.b;
		side_s2.lin <= lin_c;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
		side_s6 <= side_s5;
		side_s7 <= side_s6;
	end

	assign mul_b = (side_s1.func == cfa_pkg::FUNC_SQR) ? side_s1.a : side_s1.b;

	always_comb begin
		case (side_s1.func)
			cfa_pkg::FUNC_ADD: lin_c = cfa_pkg::LIN_W'(side_s1.a) + cfa_pkg::LIN_W'(side_s1.b);
			cfa_pkg::FUNC_SUB: lin_c = cfa_pkg::LIN_W'(side_s1.a) + cfa_pkg::FOUR_P -
				cfa_pkg::LIN_W'(side_s1.b);
			default: lin_c = cfa_pkg::LIN_W'(side_s1.a);
		endcase
	end

	cfa_mul u_mul (
		.clk(clk),
		.x(side_s1.a),
		.y(mul_b),
		.fold_s4(fold_s4)
	);

	always_comb begin
		va = '0;
		vb = '0;
		vc = '0;
		for (int k = 0; k < cfa_pkg::LIMBS; k++) begin
			va[32*k +: 32] = fold_s4[k][31:0];
			vb[32*k+32 +: 32] = fold_s4[k][63:32];
			vc[32*k+64 +: 9] = fold_s4[k][72:64];
		end
	end

	always_ff @(posedge clk) begin
		if (side_s4.func == cfa_pkg::FUNC_MUL || side_s4.func == cfa_pkg::FUNC_SQR) begin
			wide_s5 <= va + vb + vc;
		end else begin
			wide_s5 <= cfa_pkg::WIDE_W'(side_s4.lin);
		end
		r1_s6 <= {1'b0, wide_s5[254:0]} +
			cfa_pkg::ELEM_W'(wide_s5[300:255] * 46'(cfa_pkg::TOP_MUL));
		r2_s7 <= {1'b0, r1_s6[254:0]} +
			(r1_s6[255] ? cfa_pkg::ELEM_W'(cfa_pkg::TOP_MUL) : '0);
	end

	assign diff = {1'b0, r2_s7} - {1'b0, cfa_pkg::PRIME};
	assign res = diff[cfa_pkg::ELEM_W] ? r2_s7 : diff[cfa_pkg::ELEM_W-1:0];
	assign emit_new = vld_s7 && side_s7.func <= cfa_pkg::FUNC_SWAP;
	assign is_swap7 = side_s7.func == cfa_pkg::FUNC_SWAP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
			last <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			done <= emit_new || pend_q;
			last <= !(emit_new && is_swap7);
			pend_q <= emit_new && is_swap7;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_new) begin
			if (is_swap7) begin
				out_q <= side_s7.swap ? side_s7.b : side_s7.a;
			end else begin
				out_q <= res;
			end
		end else begin
			out_q <= pend_data_q;
		end
		pend_data_q <= side_s7.swap ? side_s7.a : side_s7.b;
	end

	assign out_word0 = out_q[63:0];
	assign out_word1 = out_q[127:64];
	assign out_word2 = out_q[191:128];
	assign out_word3 = out_q[254:192];

	`CFA_ASSERT(a_busy_after_swap, clk, arst_n, busy |-> $past(start) && $past(func) == cfa_pkg::FUNC_SWAP, "busy raised without a swap beat")
	`CFA_ASSERT(a_swap_pair, clk, arst_n, done && !last |=> done && last, "first swap result not followed by the second")
	`CFA_NEVER(a_no_overlap, clk, arst_n, pend_q && emit_new, "pending swap result collides with a new result")

endmodule

>>> bench/tb_curve25519_field_alu.sv
// Self-checking testbench of the GF(2^255-19) arithmetic unit: directed and random items,
// results predicted with wide integer arithmetic and checked beat by beat in a scoreboard.
// Depends on cfa_pkg and curve25519_field_alu.
`timescale 1ns / 1ps

module tb_curve25519_field_alu;

	typedef struct packed {
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [62:0] w3;
		logic        last;
	} beat_t;

	localparam logic [511:0] P_WIDE = 512'(cfa_pkg::PRIME);

	int errors = 0;
	int beats_seen = 0;
	int items_sent = 0;

	task automatic report(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	function automatic beat_t make_beat(logic [255:0] v, logic lst);
		beat_t b;
		b.w0 = v[63:0];
		b.w1 = v[127:64];
		b.w2 = v[191:128];
		b.w3 = v[254:192];
		b.last = lst;
		return b;
	endfunction

	class field_scoreboard;
		beat_t pending[$];

		function void note_item(logic [2:0] op, logic [255:0] a, logic [255:0] b, logic sw);
			logic [511:0] x, y, r;
			x = 512'(a) % P_WIDE;
			y = 512'(b) % P_WIDE;
			case (op)
				cfa_pkg::FUNC_ADD: r = (x + y) % P_WIDE;
				cfa_pkg::FUNC_SUB: r = (x + P_WIDE - y) % P_WIDE;
				cfa_pkg::FUNC_MUL: r = (x * y) % P_WIDE;
				cfa_pkg::FUNC_SQR: r = (x * x) % P_WIDE;
				cfa_pkg::FUNC_RED: r = x;
				default: r = '0;
			endcase
			if (op == cfa_pkg::FUNC_SWAP) begin
				pending.push_back(make_beat(sw ? b : a, 1'b0));
				pending.push_back(make_beat(sw ? a : b, 1'b1));
			end else if (op <= cfa_pkg::FUNC_RED) begin
				pending.push_back(make_beat(r[255:0], 1'b1));
			end
		endfunction

		task check_beat(beat_t got);
			beat_t exp;
			if (pending.size() == 0) begin
				report("result beat with nothing expected");
				return;
			end
			exp = pending.pop_front();
			if (got.w0 !== exp.w0) report($sformatf("out_word0 %h, expected %h", got.w0, exp.w0));
			if (got.w1 !== exp.w1) report($sformatf("out_word1 %h, expected %h", got.w1, exp.w1));
			if (got.w2 !== exp.w2) report($sformatf("out_word2 %h, expected %h", got.w2, exp.w2));
			if (got.w3 !== exp.w3) report($sformatf("out_word3 %h, expected %h", got.w3, exp.w3));
			if (got.last !== exp.last) report($sformatf("last %b, expected %b", got.last, exp.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] func = '0;
	logic [63:0] a_word0 = '0, a_word1 = '0, a_word2 = '0, a_word3 = '0;
	logic [63:0] b_word0 = '0, b_word1 = '0, b_word2 = '0, b_word3 = '0;
	logic swap_bit = 1'b0;
	logic done;
	logic [63:0] out_word0, out_word1, out_word2;
	logic [62:0] out_word3;
	logic last;

	field_scoreboard sb = new();
	int idle_pct = 0;

	curve25519_field_alu dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.a_word0(a_word0), .a_word1(a_word1), .a_word2(a_word2), .a_word3(a_word3),
		.b_word0(b_word0), .b_word1(b_word1), .b_word2(b_word2), .b_word3(b_word3),
		.swap_bit(swap_bit), .done(done), .out_word0(out_word0), .out_word1(out_word1),
		.out_word2(out_word2), .out_word3(out_word3), .last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			beats_seen++;
			sb.check_beat({out_word0, out_word1, out_word2, out_word3, last});
		end
	end

	function automatic logic [255:0] rand_elem();
		logic [255:0] v;
		int k;
		for (k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
		case ($urandom_range(0, 9))
			0: v = cfa_pkg::PRIME - 256'($urandom_range(0, 3));
			1: v = cfa_pkg::PRIME + 256'($urandom_range(0, 40));
			2: v = '1 - 256'($urandom_range(0, 3));
			3: v = 256'($urandom_range(0, 3));
			default: ;
		endcase
		return v;
	endfunction

	// Presents one item and holds it until the block takes it.
	task automatic send_item(logic [2:0] op, logic [255:0] a, logic [255:0] b, logic sw);
		logic taken;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		func <= op;
		{a_word3, a_word2, a_word1, a_word0} <= a;
		{b_word3, b_word2, b_word1, b_word0} <= b;
		swap_bit <= sw;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		sb.note_item(op, a, b, sw);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic random_items(int n);
		logic [2:0] op;
		repeat (n) begin
			op = 3'($urandom_range(0, 7));
			if (op > 3'd5 && $urandom_range(0, 3) != 0) op = 3'($urandom_range(0, 5));
			send_item(op, rand_elem(), rand_elem(), 1'($urandom));
		end
	endtask

	initial begin
		logic [255:0] ones;
		int f;
		ones = '1;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (f = 0; f < 8; f++) begin
			send_item(3'(f), ones, ones, 1'b1);
			send_item(3'(f), cfa_pkg::PRIME, cfa_pkg::PRIME - 256'd1, 1'b0);
		end
		send_item(cfa_pkg::FUNC_SUB, '0, 256'd1, 1'b0);
		send_item(cfa_pkg::FUNC_SUB, 256'd5, cfa_pkg::PRIME + 256'd5, 1'b0);
		send_item(cfa_pkg::FUNC_ADD, cfa_pkg::PRIME - 256'd1, cfa_pkg::PRIME - 256'd1, 1'b0);
		send_item(cfa_pkg::FUNC_MUL, cfa_pkg::PRIME - 256'd1, cfa_pkg::PRIME - 256'd1, 1'b0);
		send_item(cfa_pkg::FUNC_RED, cfa_pkg::PRIME + 256'd18, '0, 1'b0);
		send_item(cfa_pkg::FUNC_SWAP, '0, ones, 1'b0);
		send_item(cfa_pkg::FUNC_MUL, '0, ones, 1'b1);
		idle_pct = 31;
		random_items(380);
		idle_pct = 77;
		random_items(380);
		idle_pct = 0;
		random_items(380);
		start <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		$display("Covered %0d items of every opcode, including invalid ones, and %0d beats.",
			items_sent, beats_seen);
		if (errors == 0 && sb.pending.size() == 0) begin
			$display("tb_curve25519_field_alu passed");
		end else begin
			$display("tb_curve25519_field_alu failed");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_curve25519_field_alu failed");
		$finish;
	end

endmodule

>>> curve25519_field_alu.f
+incdir+src
src/cfa_pkg.sv
src/cfa_mul.sv
src/curve25519_field_alu.sv
bench/tb_curve25519_field_alu.sv
